FILE: src/dcda_pkg.sv
`timescale 1ns / 1ps

package dcda_pkg;

  // Field and state widths
  localparam int MV_W        = 12;
  localparam int CNT_W       = 16;
  localparam int ACC_W       = MV_W + CNT_W;
  localparam int SUM_W       = 16;
  localparam int WINDOW      = 16;
  localparam int POS_W       = $clog2(WINDOW);
  localparam int FILL_W      = $clog2(WINDOW + 1);
  localparam int PROD_W      = 2 * MV_W;

  // Limits and scaling constants
  localparam logic [CNT_W-1:0]  MAX_SAMPLES   = 16'd65535;
  localparam logic [MV_W-1:0]   ADC_FULL_CODE = 12'd4095;
  localparam logic [MV_W-1:0]   FULL_SCALE_RST = 12'd3300;
  localparam logic [FILL_W-1:0] WINDOW_FILL   = FILL_W'(WINDOW);

  // Shared divider geometry: dividend up to ACC_W bits, divisor CNT_W bits
  localparam int DIVD_W    = ACC_W;
  localparam int DIVS_W    = CNT_W;
  localparam int DIV_STEPS = DIVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_MV = 2'd2;

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  // Request into the shared divider
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  // Shared write control for both averaging rings
  typedef struct packed {
    logic             push;
    logic [POS_W-1:0] pos;
  } ring_req_t;

endpackage

FILE: src/dual_current_decimate_average.sv
`timescale 1ns / 1ps

// Two-channel current conditioner. A sample transaction (cmd 0) adds one
// ADC code per channel to its accumulator, up to 65535 pairs; later
// samples are dropped. A dump transaction (cmd 1) averages each channel,
// removes the zero offset, scales to millivolts, pushes the value into a
// 16-entry moving-average ring and returns the rounded mean of the filled
// entries as one result. The four divisions by a count in a dump (average
// and mean, per channel) run on one shared restoring divider. The scaling
// by full_scale/4095 is a multiply followed by a shift-and-add divide per
// channel. in_stall is high from an accepted dump until its result is in
// the output register, longer if the previous result is still waiting
// there. The result sits in an output register, so samples are taken
// while it waits.
module dual_current_decimate_average (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [dcda_pkg::MV_W-1:0]            in_sample_a,
  input  logic [dcda_pkg::MV_W-1:0]            in_sample_b,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dcda_pkg::MV_W-1:0]            out_current_a_mv,
  output logic [dcda_pkg::MV_W-1:0]            out_current_b_mv,
  // configuration port
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dcda_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcda_pkg::MV_W-1:0]            cfg_data
);
  import dcda_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_AVG  = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_MV   = 7'b0001000,
    ST_PUSH = 7'b0010000,
    ST_MEAN = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [MV_W-1:0]   offset_a_r, offset_b_r, full_scale_r;
  logic [ACC_W-1:0]  accum_a_r, accum_a_nxt, accum_b_r, accum_b_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ch_r, ch_nxt;
  logic              issued_r, issued_nxt;
  logic [MV_W-1:0]   avg_r, avg_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [MV_W-1:0]   mv_a_r, mv_a_nxt, mv_b_r, mv_b_nxt;
  logic [MV_W-1:0]   res_a_r, res_a_nxt, res_b_r, res_b_nxt;
  logic [MV_W-1:0]   out_a_r, out_a_nxt, out_b_r, out_b_nxt;
  logic              out_valid_r, out_valid_nxt;

  div_req_t          div_req;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;
  ring_req_t         ring_req;
  logic [SUM_W-1:0]  sum_a, sum_b;

  logic              in_accept;
  logic [MV_W-1:0]   off_sel, raw;
  logic [ACC_W-1:0]  accum_sel;
  logic [SUM_W-1:0]  sum_sel;
  logic [PROD_W-1:0] scale_sum;
  logic [MV_W-1:0]   mv_q;

  dcda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  dcda_ring u_ring_a (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .value (mv_a_r),
    .sum   (sum_a)
  );

  dcda_ring u_ring_b (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .value (mv_b_r),
    .sum   (sum_b)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Channel operand selection
  assign off_sel   = ch_r ? offset_b_r : offset_a_r;
  assign accum_sel = ch_r ? accum_b_r : accum_a_r;
  assign sum_sel   = ch_r ? sum_b : sum_a;
  assign raw       = (avg_r > off_sel) ? (avg_r - off_sel) : '0;

  // Divide by 4095 = 2^12 - 1: (x + (x >> 12) + 1) >> 12, exact for x <= 4095 * 4095
  assign scale_sum = prod_r + (prod_r >> MV_W) + PROD_W'(1);
  assign mv_q      = scale_sum[PROD_W-1:MV_W];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    accum_a_nxt   = accum_a_r;
    accum_b_nxt   = accum_b_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    ch_nxt        = ch_r;
    issued_nxt    = issued_r;
    avg_nxt       = avg_r;
    prod_nxt      = prod_r;
    mv_a_nxt      = mv_a_r;
    mv_b_nxt      = mv_b_r;
    res_a_nxt     = res_a_r;
    res_b_nxt     = res_b_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_req       = '0;
    ring_req      = '0;
    ring_req.pos  = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_DUMP) begin
            ch_nxt     = 1'b0;
            issued_nxt = 1'b0;
            state_nxt  = ST_AVG;
          end else if (count_r < MAX_SAMPLES) begin
            accum_a_nxt = accum_a_r + ACC_W'(in_sample_a);
            accum_b_nxt = accum_b_r + ACC_W'(in_sample_b);
            count_nxt   = count_r + 1'b1;
          end
        end
      end
      ST_AVG: begin
        // accumulator / count; an empty count averages to zero
        if (!issued_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = accum_sel;
          div_req.divisor  = count_r;
          issued_nxt       = 1'b1;
        end else if (div_done) begin
          avg_nxt    = (count_r == '0) ? '0 : div_quo[MV_W-1:0];
          issued_nxt = 1'b0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(raw) * PROD_W'(full_scale_r);
        state_nxt = ST_MV;
      end
      ST_MV: begin
        // product / 4095, truncated
        if (!ch_r) begin
          mv_a_nxt  = mv_q;
          ch_nxt    = 1'b1;
          state_nxt = ST_AVG;
        end else begin
          mv_b_nxt    = mv_q;
          accum_a_nxt = '0;
          accum_b_nxt = '0;
          count_nxt   = '0;
          if (fill_r < WINDOW_FILL) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ring_req.push = 1'b1;
        pos_nxt       = pos_r + 1'b1;
        ch_nxt        = 1'b0;
        state_nxt     = ST_MEAN;
      end
      ST_MEAN: begin
        // rounded mean over filled entries
        if (!issued_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'(sum_sel) + DIVD_W'(fill_r >> 1);
          div_req.divisor  = DIVS_W'(fill_r);
          issued_nxt       = 1'b1;
        end else if (div_done) begin
          issued_nxt = 1'b0;
          if (!ch_r) begin
            res_a_nxt = div_quo[MV_W-1:0];
            ch_nxt    = 1'b1;
          end else begin
            res_b_nxt = div_quo[MV_W-1:0];
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_a_nxt     = res_a_r;
          out_b_nxt     = res_b_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accum_a_r   <= '0;
      accum_b_r   <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      ch_r        <= 1'b0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      accum_a_r   <= accum_a_nxt;
      accum_b_r   <= accum_b_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      ch_r        <= ch_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
    avg_r   <= avg_nxt;
    prod_r  <= prod_nxt;
    mv_a_r  <= mv_a_nxt;
    mv_b_r  <= mv_b_nxt;
    res_a_r <= res_a_nxt;
    res_b_r <= res_b_nxt;
    out_a_r <= out_a_nxt;
    out_b_r <= out_b_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_a_r   <= '0;
      offset_b_r   <= '0;
      full_scale_r <= FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OFFSET_A:      offset_a_r   <= cfg_data;
        REG_OFFSET_B:      offset_b_r   <= cfg_data;
        REG_FULL_SCALE_MV: full_scale_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_current_a_mv = out_a_r;
  assign out_current_b_mv = out_b_r;

endmodule

FILE: src/dcda_div.sv
`timescale 1ns / 1ps

module dcda_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dcda_pkg::div_req_t       req,
  output logic                     done,
  output logic [dcda_pkg::DIVD_W-1:0] quotient
);
  import dcda_pkg::*;

  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVD_W-1:0]    quo_r, quo_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DIVS_W:0] trial;
  logic            ge;

  // One restoring step per cycle: shift in next dividend bit, try subtract
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIVS_W'(trial - {1'b0, dvs_r}) : trial[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/dcda_ring.sv
`timescale 1ns / 1ps

module dcda_ring (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dcda_pkg::ring_req_t        req,
  input  logic [dcda_pkg::MV_W-1:0]  value,
  output logic [dcda_pkg::SUM_W-1:0] sum
);
  import dcda_pkg::*;

  logic [MV_W-1:0]  ring_r [WINDOW];
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Running window sum: add the new entry, drop the one it replaces
  assign sum_nxt = sum_r + SUM_W'(value) - SUM_W'(ring_r[req.pos]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else if (req.push) begin
      sum_r           <= sum_nxt;
      ring_r[req.pos] <= value;
    end
  end

  assign sum = sum_r;

endmodule
